[rtl/lps_pkg.sv]
package lps_pkg;

  // Field widths of the sample and result streams.
  localparam int SAMPLE_W    = 24;
  localparam int RESULT_W    = 28;
  localparam int SUM_W       = SAMPLE_W + 2;
  localparam int TDATA_OUT_W = 32;
  localparam int TUSER_W     = 2;

  // Configuration register file.
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;
  localparam logic [ROWS_CFG_W-1:0] RESET_ROWS = 11'd32;
  localparam logic [COLS_CFG_W-1:0] RESET_COLS = 6'd32;

  // Output queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // What an item in the pipeline stands for.
  typedef enum logic [1:0] {
    ITEM_STEP,   // a grid sample entering the window
    ITEM_HOLD,   // flush: center of the window after the last sample
    ITEM_LINE    // flush: one entry of the lower line store
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_HOLD,
    ST_LINE
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
    logic       emit;
    logic       bnd;
    logic       eof;
    logic       last;
  } item_ctl_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic                       bnd;
    logic                       eof;
    logic                       last;
  } result_t;

endpackage

[rtl/nine_point_laplacian_stencil_core.sv]
// Nine-point Laplacian stencil over a raster stream of grid samples.
// Samples (signed, 16 fraction bits) enter on the s_axis channel one per
// transaction, row by row. Results leave on m_axis in raster order, one per
// grid point: interior points give eight times the center minus the eight
// neighbors, boundary points are copied and flagged in tuser.
// The grid size is written on the cfg channel (index 0 rows, index 1 columns)
// and is taken up at the first sample of each frame.
// Throughput is one sample per cycle while the output queue has room. The
// result of the sample that completes a window passes pipeline stages one and
// two and is then registered in the output queue before m_axis_tvalid rises;
// in stream terms results trail by one row plus one column. The last sample
// of a frame also releases the remaining columns + 1 results: the flush
// sequencer issues the held center and then reads the lower line store one
// entry per cycle while the queue has room, and s_axis_tready is low.
// When m_axis stalls, results collect in a four-entry output queue; tready
// drops once the queued results plus the items in both stages reach four.
// Reset returns the position to the frame origin and the size to 32 x 32.
// The line stores are not cleared; no result depends on an unwritten entry.
module nine_point_laplacian_stencil_core
  import lps_pkg::*;
#(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [23:0] sample_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [27:0] result_value, [31:28] zero
  output logic [TUSER_W-1:0]     m_axis_tuser,   // [0] boundary_point, [1] end_of_frame
  output logic                   m_axis_tlast,   // last_of_run
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ROWS_CFG_W-1:0]  cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam logic [RW-1:0] ROWS_TOP = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] COLS_TOP = CW'(MAX_COLS - 1);

  logic [ROWS_CFG_W-1:0] grid_rows;
  logic [COLS_CFG_W-1:0] grid_cols;
  seq_state_t            st, st_next;
  logic [RW-1:0]         row, row_next;
  logic [CW-1:0]         col, col_next;
  logic [CW-1:0]         idx, idx_next;
  logic [RW-1:0]         act_rm1, act_rm1_next;
  logic [CW-1:0]         act_cm1, act_cm1_next;
  logic [RW-1:0]         rows_m1_cfg;
  logic [CW-1:0]         cols_m1_cfg;
  logic [RW-1:0]         cur_rm1;
  logic [CW-1:0]         cur_cm1;
  logic                  origin;
  logic                  c_nz;
  logic [RW-1:0]         tr;
  logic [CW-1:0]         tc;
  logic                  step_emit;
  logic                  step_bnd;
  logic                  last_sample;
  item_ctl_t             issue;
  logic [CW-1:0]         rd_addr;
  logic                  res_valid;
  result_t               res;
  logic [1:0]            busy;
  result_t               fifo_dout;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  fifo_pop;
  logic [FIFO_CNT_W:0]   credit;
  logic                  room;
  logic                  in_acc;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= RESET_ROWS;
      grid_cols <= RESET_COLS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_ROWS: grid_rows <= cfg_data;
        CFG_GRID_COLS: grid_cols <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the written size to the supported range, kept as size minus one.
  always_comb begin
    if (grid_rows < 11'd3) begin
      rows_m1_cfg = RW'(2);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      rows_m1_cfg = ROWS_TOP;
    end else begin
      rows_m1_cfg = RW'(grid_rows - 11'd1);
    end
    if (grid_cols < 6'd3) begin
      cols_m1_cfg = CW'(2);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_m1_cfg = COLS_TOP;
    end else begin
      cols_m1_cfg = CW'(grid_cols - 6'd1);
    end
  end

  // Position of the incoming sample and the point whose window it completes.
  always_comb begin
    origin      = (row == '0) && (col == '0);
    cur_rm1     = origin ? rows_m1_cfg : act_rm1;
    cur_cm1     = origin ? cols_m1_cfg : act_cm1;
    c_nz        = (col != '0);
    tr          = c_nz ? row - RW'(1) : row - RW'(2);
    tc          = c_nz ? col - CW'(1) : cur_cm1;
    step_emit   = (row > RW'(1)) || ((row == RW'(1)) && c_nz);
    step_bnd    = (tr == '0) || (tr == cur_rm1) || (tc == '0) || (tc == cur_cm1);
    last_sample = (row == cur_rm1) && (col == cur_cm1);
  end

  // Credit: every item in flight may still need a queue slot.
  assign credit = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(busy);
  assign room   = credit < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_RUN;
      row     <= '0;
      col     <= '0;
      idx     <= '0;
      act_rm1 <= ROWS_TOP;
      act_cm1 <= COLS_TOP;
    end else begin
      st      <= st_next;
      row     <= row_next;
      col     <= col_next;
      idx     <= idx_next;
      act_rm1 <= act_rm1_next;
      act_cm1 <= act_cm1_next;
    end
  end

  // Sample acceptance and the end-of-frame flush.
  always_comb begin
    st_next       = st;
    row_next      = row;
    col_next      = col;
    idx_next      = idx;
    act_rm1_next  = act_rm1;
    act_cm1_next  = act_cm1;
    issue         = '0;
    rd_addr       = col;
    s_axis_tready = 1'b0;
    case (st)
      ST_RUN: begin
        s_axis_tready = room;
        if (s_axis_tvalid && room) begin
          issue.valid = 1'b1;
          issue.kind  = ITEM_STEP;
          issue.emit  = step_emit;
          issue.bnd   = step_bnd;
          issue.eof   = 1'b0;
          issue.last  = !last_sample;
          if (origin) begin
            act_rm1_next = rows_m1_cfg;
            act_cm1_next = cols_m1_cfg;
          end
          if (last_sample) begin
            row_next = '0;
            col_next = '0;
            st_next  = ST_HOLD;
          end else if (col == cur_cm1) begin
            row_next = row + 1'b1;
            col_next = '0;
          end else begin
            col_next = col + 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (room) begin
          issue.valid = 1'b1;
          issue.kind  = ITEM_HOLD;
          issue.emit  = 1'b1;
          issue.bnd   = 1'b1;
          idx_next    = '0;
          st_next     = ST_LINE;
        end
      end
      ST_LINE: begin
        rd_addr = idx;
        if (room) begin
          issue.valid = 1'b1;
          issue.kind  = ITEM_LINE;
          issue.emit  = 1'b1;
          issue.bnd   = 1'b1;
          issue.eof   = (idx == act_cm1);
          issue.last  = (idx == act_cm1);
          if (idx == act_cm1) begin
            idx_next = '0;
            st_next  = ST_RUN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: st_next = ST_RUN;
    endcase
  end

  lps_stencil_pipe #(.MAX_COLS(MAX_COLS)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .sample    (s_axis_tdata),
    .rd_addr   (rd_addr),
    .res_valid (res_valid),
    .res       (res),
    .busy      (busy)
  );

  assign fifo_pop = m_axis_tvalid && m_axis_tready;

  lps_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (fifo_pop),
    .dout  (fifo_dout),
    .count (fifo_cnt)
  );

  // Output channel.
  assign m_axis_tvalid = (fifo_cnt != '0);
  assign m_axis_tdata  = {{(TDATA_OUT_W - RESULT_W){1'b0}}, fifo_dout.value};
  assign m_axis_tuser  = {fifo_dout.eof, fifo_dout.bnd};
  assign m_axis_tlast  = fifo_dout.last;

  // The credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (fifo_cnt == FIFO_CNT_W'(FIFO_DEPTH))) |-> fifo_pop)
    else $error("output queue overflow");

  // The final sample of a frame starts the flush at the frame origin.
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_sample) |=> ((st == ST_HOLD) && (row == '0) && (col == '0)))
    else $error("flush did not start after the last sample");

  // Mid-frame positions stay inside the latched grid size.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN) |-> ((col <= act_cm1) && (row <= act_rm1)))
    else $error("raster position outside the grid");

  // End of frame is always a copied boundary point closing its transaction run.
  a_eof_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && m_axis_tuser[0]))
    else $error("end of frame without last and boundary flags");

endmodule

[rtl/lps_ram.sv]
module lps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lps_stencil_pipe.sv]
module lps_stencil_pipe
  import lps_pkg::*;
#(
  parameter int MAX_COLS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  item_ctl_t                   issue,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
  output logic                        res_valid,
  output result_t                     res,
  output logic [1:0]                  busy
);

  localparam int AW = $clog2(MAX_COLS);

  item_ctl_t                  s1_ctl;
  item_ctl_t                  s2_ctl;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [AW-1:0]              s1_addr;
  logic signed [SAMPLE_W-1:0] top_q;
  logic signed [SAMPLE_W-1:0] mid_q;
  logic signed [SAMPLE_W-1:0] w0, w1, w2, w3, w4, w5;
  logic                       step_wr;
  logic                       rd_en;
  logic signed [SAMPLE_W-1:0] center_s1;
  logic signed [SUM_W-1:0]    pa_s1;
  logic signed [SUM_W-1:0]    pb_s1;
  logic signed [SAMPLE_W-1:0] s2_center;
  logic signed [SUM_W-1:0]    s2_pa;
  logic signed [SUM_W-1:0]    s2_pb;

  // The hold item uses the window only, so it does not touch the line stores.
  assign rd_en   = issue.valid && (issue.kind != ITEM_HOLD);
  assign step_wr = s1_ctl.valid && (s1_ctl.kind == ITEM_STEP);

  // Upper store gets the row one above, lower store gets the current row.
  lps_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_upper (
    .clk   (clk),
    .we    (step_wr),
    .waddr (s1_addr),
    .wdata (mid_q),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (top_q)
  );

  lps_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_lower (
    .clk   (clk),
    .we    (step_wr),
    .waddr (s1_addr),
    .wdata (s1_x),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (mid_q)
  );

  // Control of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else begin
      s1_ctl <= issue;
      s2_ctl <= s1_ctl;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    s1_x    <= sample;
    s1_addr <= rd_addr;
  end

  // Window columns shift on every sample once its line store data is back.
  always_ff @(posedge clk) begin
    if (rst) begin
      w0 <= '0;
      w1 <= '0;
      w2 <= '0;
      w3 <= '0;
      w4 <= '0;
      w5 <= '0;
    end else if (step_wr) begin
      w0 <= w3;
      w1 <= w4;
      w2 <= w5;
      w3 <= top_q;
      w4 <= mid_q;
      w5 <= s1_x;
    end
  end

  // Neighbor sums in two halves; the center is the copied value for boundary items.
  always_comb begin
    center_s1 = (s1_ctl.kind == ITEM_LINE) ? mid_q : w4;
    pa_s1 = SUM_W'(w0) + SUM_W'(w1) + SUM_W'(w2) + SUM_W'(w3);
    pb_s1 = SUM_W'(w5) + SUM_W'(top_q) + SUM_W'(mid_q) + SUM_W'(s1_x);
  end

  always_ff @(posedge clk) begin
    s2_center <= center_s1;
    s2_pa     <= pa_s1;
    s2_pb     <= pb_s1;
  end

  // Stage two: eight times the center minus the neighbors, or a plain copy.
  always_comb begin
    if (s2_ctl.bnd) begin
      res.value = RESULT_W'(s2_center);
    end else begin
      res.value = (RESULT_W'(s2_center) <<< 3) - RESULT_W'(s2_pa) - RESULT_W'(s2_pb);
    end
    res.bnd   = s2_ctl.bnd;
    res.eof   = s2_ctl.eof;
    res.last  = s2_ctl.last;
    res_valid = s2_ctl.valid && s2_ctl.emit;
  end

  assign busy = {1'b0, s1_ctl.valid} + {1'b0, s2_ctl.valid};

endmodule

[rtl/lps_out_fifo.sv]
module lps_out_fifo
  import lps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               din,
  input  logic                  pop,
  output result_t               dout,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout = mem[rd_ptr];

endmodule
